// File: design/pffa_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the page frame free-list allocator.
// No dependencies.
package pffa_pkg;

  localparam int FRAME_W  = 52;
  localparam int GIVEN_W  = 53;
  localparam int PCNT_W   = 13;
  localparam int STATUS_W = 2;
  localparam int APB_DW   = 64;
  localparam int APB_AW   = 4;

  // Register index is paddr bit 3 (8-byte register stride)
  localparam logic REG_BASE_FRAME = 1'b0;
  localparam logic REG_PAGE_COUNT = 1'b1;

  localparam logic [PCNT_W-1:0] PAGE_COUNT_RST = 13'd4096;

  typedef enum logic {
    ACT_ALLOC = 1'b0,
    ACT_FREE  = 1'b1
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_RANGE    = 2'd2,
    ST_NOT_USED = 2'd3
  } status_e;

  typedef struct packed {
    logic [FRAME_W-1:0] base_frame;
    logic [PCNT_W-1:0]  page_count;
  } cfg_t;

endpackage

// File: design/pffa_cfg_regs.sv
`timescale 1ns / 1ps
// APB register file: base_frame and page_count.
// Depends on pffa_pkg.
module pffa_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pffa_pkg::APB_AW-1:0]  paddr,
  input  logic [pffa_pkg::APB_DW-1:0]  pwdata,
  output logic [pffa_pkg::APB_DW-1:0]  prdata,
  output logic                         pready,
  output pffa_pkg::cfg_t               cfg_o
);

  pffa_pkg::cfg_t cfg_q;
  logic           wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.base_frame <= '0;
      cfg_q.page_count <= pffa_pkg::PAGE_COUNT_RST;
    end else if (wr_en) begin
      unique case (paddr[3])
        pffa_pkg::REG_BASE_FRAME: cfg_q.base_frame <= pwdata[pffa_pkg::FRAME_W-1:0];
        pffa_pkg::REG_PAGE_COUNT: cfg_q.page_count <= pwdata[pffa_pkg::PCNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3])
      pffa_pkg::REG_BASE_FRAME: prdata = pffa_pkg::APB_DW'(cfg_q.base_frame);
      pffa_pkg::REG_PAGE_COUNT: prdata = pffa_pkg::APB_DW'(cfg_q.page_count);
      default:                  prdata = '0;
    endcase
  end

endmodule

// File: design/pffa_ram.sv
`timescale 1ns / 1ps
// Simple dual-port synchronous RAM, one write and one read port, registered read.
// No dependencies.
module pffa_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// File: design/page_frame_free_list_allocator_core.sv
`timescale 1ns / 1ps
// Page frame free-list allocator: LIFO freed stack plus fresh-frame counter.
// Each item steps through accept (S_IDLE), memory read (S_READ) and read-modify-write (S_EXEC);
// the result is registered on leaving S_EXEC. A new item is taken only once the last is done,
// and S_EXEC waits while the output register is held by the downstream side.
// Reset: stack empty, no page in use; in-use bits at or above the fresh counter read as clear.
// Depends on pffa_pkg, pffa_cfg_regs, pffa_ram.
module page_frame_free_list_allocator_core #(
  parameter int MAX_PAGES = 4096
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // APB configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pffa_pkg::APB_AW-1:0]  paddr,
  input  logic [pffa_pkg::APB_DW-1:0]  pwdata,
  output logic [pffa_pkg::APB_DW-1:0]  prdata,
  output logic                         pready,
  // request stream
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [55:0]                  s_axis_tdata,  // [51:0] frame_number, [55:52] zero
  input  logic [0:0]                   s_axis_tuser,  // [0] action
  // result stream
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [71:0]                  m_axis_tdata,  // [52:0] given_frame, [65:53] used_pages
  output logic [1:0]                   m_axis_tuser   // [1:0] status
);

  localparam int IW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int CW = IW + 1;
  localparam int EW = (CW > pffa_pkg::PCNT_W) ? CW : pffa_pkg::PCNT_W;
  localparam logic [CW-1:0] MaxPages = CW'(MAX_PAGES);
  localparam logic [EW-1:0] MaxPagesE = EW'(MAX_PAGES);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EXEC
  } state_e;

  pffa_pkg::cfg_t cfg;

  pffa_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg)
  );

  state_e                        state_q;
  logic                          act_q;
  logic                          range_ok_q;
  logic [IW-1:0]                 idx_q;
  logic [CW-1:0]                 top_q;
  logic [CW-1:0]                 next_q;
  logic [CW-1:0]                 used_q;
  logic                          out_valid_q;
  logic [pffa_pkg::STATUS_W-1:0] out_status_q;
  logic [pffa_pkg::GIVEN_W-1:0]  out_given_q;
  logic [pffa_pkg::PCNT_W-1:0]   out_used_q;

  logic [EW-1:0]                 eff_count;
  logic [pffa_pkg::GIVEN_W-1:0]  diff;
  logic                          range_ok;
  logic                          in_fire;
  logic                          exec_go;

  logic                          stk_we;
  logic [IW-1:0]                 stk_waddr;
  logic [IW-1:0]                 stk_rdata;
  logic                          use_we;
  logic [IW-1:0]                 use_waddr;
  logic [0:0]                    use_wdata;
  logic [0:0]                    use_rdata;
  logic                          rd_en;
  logic [IW-1:0]                 pop_addr;

  logic [pffa_pkg::STATUS_W-1:0] ex_status;
  logic [IW-1:0]                 ex_idx;
  logic                          ex_alloc_ok;
  logic                          ex_from_stack;
  logic                          ex_free_ok;
  logic                          ex_in_use;
  logic [CW-1:0]                 pop_top;
  logic [pffa_pkg::GIVEN_W-1:0]  ex_given;
  logic [CW-1:0]                 ex_used;

  always_comb begin
    eff_count = (EW'(cfg.page_count) > MaxPagesE) ? MaxPagesE : EW'(cfg.page_count);
    diff      = {1'b0, s_axis_tdata[pffa_pkg::FRAME_W-1:0]} - {1'b0, cfg.base_frame};
    range_ok  = !diff[pffa_pkg::GIVEN_W-1] &&
                (diff[pffa_pkg::FRAME_W-1:0] < pffa_pkg::FRAME_W'(eff_count));
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign rd_en         = (state_q == S_READ);
  assign pop_top       = top_q - 1'b1;
  assign pop_addr      = pop_top[IW-1:0];

  pffa_ram #(
    .WIDTH(IW),
    .DEPTH(MAX_PAGES)
  ) u_stack (
    .clk_i  (clk_i),
    .we_i   (stk_we),
    .waddr_i(stk_waddr),
    .wdata_i(idx_q),
    .re_i   (rd_en),
    .raddr_i(pop_addr),
    .rdata_o(stk_rdata)
  );

  pffa_ram #(
    .WIDTH(1),
    .DEPTH(MAX_PAGES)
  ) u_in_use (
    .clk_i  (clk_i),
    .we_i   (use_we),
    .waddr_i(use_waddr),
    .wdata_i(use_wdata),
    .re_i   (rd_en),
    .raddr_i(idx_q),
    .rdata_o(use_rdata)
  );

  always_comb begin
    exec_go       = (state_q == S_EXEC) && (!out_valid_q || m_axis_tready);
    ex_from_stack = (top_q != '0);
    ex_alloc_ok   = ex_from_stack || (EW'(next_q) < eff_count);
    ex_idx        = ex_from_stack ? stk_rdata : next_q[IW-1:0];
    // entries at or above the fresh counter were never allocated
    ex_in_use     = (CW'(idx_q) < next_q) ? use_rdata[0] : 1'b0;
    ex_free_ok    = range_ok_q && ex_in_use;

    if (act_q == pffa_pkg::ACT_ALLOC) begin
      ex_status = ex_alloc_ok ? pffa_pkg::ST_OK : pffa_pkg::ST_FULL;
    end else if (!range_ok_q) begin
      ex_status = pffa_pkg::ST_RANGE;
    end else if (!ex_in_use) begin
      ex_status = pffa_pkg::ST_NOT_USED;
    end else begin
      ex_status = pffa_pkg::ST_OK;
    end

    ex_given = '0;
    ex_used  = used_q;
    if (act_q == pffa_pkg::ACT_ALLOC) begin
      if (ex_alloc_ok) begin
        ex_given = pffa_pkg::GIVEN_W'(cfg.base_frame) + pffa_pkg::GIVEN_W'(ex_idx);
        ex_used  = used_q + 1'b1;
      end
    end else if (ex_free_ok && (used_q != '0)) begin
      ex_used = used_q - 1'b1;
    end

    use_we    = 1'b0;
    use_waddr = idx_q;
    use_wdata = 1'b0;
    stk_we    = 1'b0;
    stk_waddr = top_q[IW-1:0];
    if (exec_go) begin
      if (act_q == pffa_pkg::ACT_ALLOC) begin
        use_we    = ex_alloc_ok;
        use_waddr = ex_idx;
        use_wdata = 1'b1;
      end else begin
        use_we = ex_free_ok;
        stk_we = ex_free_ok && (top_q < MaxPages);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      act_q        <= pffa_pkg::ACT_ALLOC;
      range_ok_q   <= 1'b0;
      idx_q        <= '0;
      top_q        <= '0;
      next_q       <= '0;
      used_q       <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= pffa_pkg::ST_OK;
      out_given_q  <= '0;
      out_used_q   <= '0;
    end else begin
      if (exec_go) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            act_q      <= s_axis_tuser[0];
            range_ok_q <= range_ok;
            idx_q      <= diff[IW-1:0];
            state_q    <= S_READ;
          end
        end
        S_READ: begin
          state_q <= S_EXEC;
        end
        S_EXEC: begin
          if (exec_go) begin
            out_status_q <= ex_status;
            out_given_q  <= ex_given;
            out_used_q   <= pffa_pkg::PCNT_W'(ex_used);
            used_q       <= ex_used;
            if (act_q == pffa_pkg::ACT_ALLOC) begin
              if (ex_alloc_ok) begin
                if (ex_from_stack) begin
                  top_q <= pop_top;
                end else begin
                  next_q <= next_q + 1'b1;
                end
              end
            end else if (ex_free_ok && (top_q < MaxPages)) begin
              top_q <= top_q + 1'b1;
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {6'd0, out_used_q, out_given_q};

endmodule
